@@ sv/ffr_pkg.sv @@
// Shared types, constants and the radix reset table for the FFT length factorizer.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ffr_pkg;

  localparam int NUM_RADICES = 6;
  localparam int LENGTH_BITS = 31;
  localparam int NUM_REGS    = 6;
  localparam int RADIX_W     = 16;
  localparam int STAGE_W     = 3;
  localparam int COUNT_W     = 5;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_CNT_W   = $clog2(LENGTH_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } ffr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic start_div;
    logic accept_div;
    logic load_out;
    logic next_stage;
  } ffr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic div_done;
    logic div_exact;
    logic last;
    logic out_free;
  } ffr_sts_t;

  // Reset values of the radix registers, and the fixed radices of stages
  // beyond the register file.
  function automatic logic [RADIX_W-1:0] reset_radix(input logic [STAGE_W-1:0] idx);
    logic [RADIX_W-1:0] val;
    unique case (idx)
      3'd0:    val = RADIX_W'(2);
      3'd1:    val = RADIX_W'(3);
      3'd2:    val = RADIX_W'(5);
      3'd3:    val = RADIX_W'(7);
      3'd4:    val = RADIX_W'(11);
      3'd5:    val = RADIX_W'(13);
      3'd6:    val = RADIX_W'(17);
      default: val = RADIX_W'(19);
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ sv/fft_length_radix_factorizer.sv @@
// Mixed-radix FFT length factorizer: one length in, one result per configured radix out.
// A trial division checks the stage and starts the shared bit-serial divider, which works
// through the quotient bits of the 31-bit length, and then takes the result. Each stage ends
// with an emit step, and the length is taken in the idle state. A length needs at most
// 36 divisions (30 exact plus one inexact per stage); output stalls can add waiting.
// Throughput: one length at a time; the next is taken after the last result is loaded.
// Reset (rst_n low, synchronous) returns the radices to 2, 3, 5, 7, 11, 13 and idles.
`timescale 1ns / 1ps
`default_nettype none

module fft_length_radix_factorizer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write port: one radix register per index.
  input  wire logic                              cfg_wr_en,
  input  wire logic [ffr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ffr_pkg::RADIX_W-1:0]       cfg_wdata,
  // Input channel: one transform length per transfer.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ffr_pkg::LENGTH_BITS-1:0]   in_fft_length,
  // Result channel: one transfer per radix stage.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [ffr_pkg::STAGE_W-1:0]       out_stage_index,
  output logic      [ffr_pkg::RADIX_W-1:0]       out_stage_radix,
  output logic      [ffr_pkg::COUNT_W-1:0]       out_factor_count,
  output logic      [ffr_pkg::LENGTH_BITS-1:0]   out_remaining_length,
  output logic                                   out_length_invalid,
  output logic                                   out_last_stage
);

  // The controller walks the stages. For each stage it either skips the
  // division (zero length, or a radix below two) or keeps dividing the
  // running length while the remainder is zero. The first inexact division
  // ends the stage; either way the stage's result is loaded into the output register.
  ffr_pkg::ffr_cmd_t cmd;
  ffr_pkg::ffr_sts_t sts;

  ffr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the radix registers, the running length and count,
  // the divider, and the result register that the output channel reads.
  // A result can wait in that register while the next stage is computed.
  ffr_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_fft_length        (in_fft_length),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_stage_index      (out_stage_index),
    .out_stage_radix      (out_stage_radix),
    .out_factor_count     (out_factor_count),
    .out_remaining_length (out_remaining_length),
    .out_length_invalid   (out_length_invalid),
    .out_last_stage       (out_last_stage)
  );

endmodule

`default_nettype wire

@@ sv/ffr_divider.sv @@
// Restoring divider, one quotient bit per cycle, for length by radix.
// Depends on ffr_pkg for the length and radix widths.
`timescale 1ns / 1ps
`default_nettype none

module ffr_divider (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [ffr_pkg::LENGTH_BITS-1:0]   dividend,
  input  wire logic [ffr_pkg::RADIX_W-1:0]       divisor,
  output logic                                   done,
  output logic      [ffr_pkg::LENGTH_BITS-1:0]   quotient,
  output logic      [ffr_pkg::RADIX_W-1:0]       remainder
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [ffr_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ffr_pkg::LENGTH_BITS-1:0]   quo_r, quo_nxt;
  logic [ffr_pkg::RADIX_W-1:0]       rem_r, rem_nxt;
  logic [ffr_pkg::RADIX_W-1:0]       dvs_r, dvs_nxt;
  logic [ffr_pkg::RADIX_W:0]         trial;
  logic [ffr_pkg::RADIX_W:0]         diff;

  assign trial = {rem_r, quo_r[ffr_pkg::LENGTH_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // No borrow means the shifted remainder reached the divisor.
      if (!diff[ffr_pkg::RADIX_W]) begin
        rem_nxt = diff[ffr_pkg::RADIX_W-1:0];
        quo_nxt = {quo_r[ffr_pkg::LENGTH_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ffr_pkg::RADIX_W-1:0];
        quo_nxt = {quo_r[ffr_pkg::LENGTH_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ffr_pkg::DIV_CNT_W'(ffr_pkg::LENGTH_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ sv/ffr_datapath.sv @@
// Datapath: radix registers, running length and count, stage counter, result register.
// Depends on ffr_pkg and instantiates ffr_divider.
`timescale 1ns / 1ps
`default_nettype none

module ffr_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ffr_pkg::ffr_cmd_t                 cmd,
  output ffr_pkg::ffr_sts_t                      sts,
  input  wire logic [ffr_pkg::LENGTH_BITS-1:0]   in_fft_length,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ffr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ffr_pkg::RADIX_W-1:0]       cfg_wdata,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [ffr_pkg::STAGE_W-1:0]       out_stage_index,
  output logic      [ffr_pkg::RADIX_W-1:0]       out_stage_radix,
  output logic      [ffr_pkg::COUNT_W-1:0]       out_factor_count,
  output logic      [ffr_pkg::LENGTH_BITS-1:0]   out_remaining_length,
  output logic                                   out_length_invalid,
  output logic                                   out_last_stage
);

  logic [ffr_pkg::RADIX_W-1:0]       radix_r [ffr_pkg::NUM_REGS];
  logic [ffr_pkg::LENGTH_BITS-1:0]   len_r, len_nxt;
  logic [ffr_pkg::COUNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ffr_pkg::STAGE_W-1:0]       stage_r, stage_nxt;
  logic                              inv_r, inv_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [ffr_pkg::STAGE_W-1:0]       out_stage_r;
  logic [ffr_pkg::RADIX_W-1:0]       out_radix_r;
  logic [ffr_pkg::COUNT_W-1:0]       out_cnt_r;
  logic [ffr_pkg::LENGTH_BITS-1:0]   out_len_r;
  logic                              out_inv_r;
  logic                              out_last_r;
  logic [ffr_pkg::RADIX_W-1:0]       cur_radix;
  logic                              last;
  logic                              out_free;
  logic                              div_done;
  logic [ffr_pkg::LENGTH_BITS-1:0]   div_quo;
  logic [ffr_pkg::RADIX_W-1:0]       div_rem;

  ffr_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start_div),
    .dividend  (len_r),
    .divisor   (cur_radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Stages past the register file use fixed radices.
  always_comb begin
    if (stage_r < ffr_pkg::STAGE_W'(ffr_pkg::NUM_REGS)) begin
      cur_radix = radix_r[stage_r[ffr_pkg::REG_IDX_W-1:0]];
    end else begin
      cur_radix = ffr_pkg::reset_radix(stage_r);
    end
  end

  assign last     = (stage_r == ffr_pkg::STAGE_W'(ffr_pkg::NUM_RADICES - 1));
  assign out_free = !out_valid_r || !out_stall;

  assign sts.skip      = inv_r || (cur_radix < ffr_pkg::RADIX_W'(2));
  assign sts.div_done  = div_done;
  assign sts.div_exact = (div_rem == '0);
  assign sts.last      = last;
  assign sts.out_free  = out_free;

  always_comb begin
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    stage_nxt = stage_r;
    inv_nxt   = inv_r;
    if (cmd.load_item) begin
      len_nxt   = in_fft_length;
      cnt_nxt   = '0;
      stage_nxt = '0;
      inv_nxt   = (in_fft_length == '0);
    end else if (cmd.accept_div) begin
      len_nxt = div_quo;
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.next_stage) begin
      cnt_nxt   = '0;
      stage_nxt = stage_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ffr_pkg::NUM_REGS; i++) begin
        radix_r[i] <= ffr_pkg::reset_radix(ffr_pkg::STAGE_W'(i));
      end
    end else if (cfg_wr_en && (cfg_index < ffr_pkg::CFG_IDX_W'(ffr_pkg::NUM_REGS))) begin
      radix_r[cfg_index[ffr_pkg::REG_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    cnt_r <= cnt_nxt;
    inv_r <= inv_nxt;
    if (cmd.load_out) begin
      out_stage_r <= stage_r;
      out_radix_r <= cur_radix;
      out_cnt_r   <= cnt_r;
      out_len_r   <= len_r;
      out_inv_r   <= inv_r;
      out_last_r  <= last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_stage_index      = out_stage_r;
  assign out_stage_radix      = out_radix_r;
  assign out_factor_count     = out_cnt_r;
  assign out_remaining_length = out_len_r;
  assign out_length_invalid   = out_inv_r;
  assign out_last_stage       = out_last_r;

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while a transfer was pending");

  a_div_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_div |-> (!inv_r && (cur_radix >= ffr_pkg::RADIX_W'(2))))
    else $error("division started for an invalid length or a radix below two");

  a_accept_exact: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_div |-> (div_done && (div_rem == '0)))
    else $error("quotient taken from an inexact or unfinished division");

  a_len_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_div |=> (len_r < $past(len_r)))
    else $error("exact division did not reduce the running length");

endmodule

`default_nettype wire

@@ sv/ffr_ctrl.sv @@
// Controller state machine: sequences stages, trial divisions and result transfers.
// Depends on ffr_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module ffr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire ffr_pkg::ffr_sts_t     sts,
  output ffr_pkg::ffr_cmd_t          cmd
);

  ffr_pkg::ffr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ffr_pkg::ST_CHECK;
        end
      end
      ffr_pkg::ST_CHECK: begin
        state_nxt = sts.skip ? ffr_pkg::ST_EMIT : ffr_pkg::ST_DIV;
      end
      ffr_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.div_exact ? ffr_pkg::ST_CHECK : ffr_pkg::ST_EMIT;
        end
      end
      ffr_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.last ? ffr_pkg::ST_IDLE : ffr_pkg::ST_CHECK;
        end
      end
      default: state_nxt = ffr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ffr_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ffr_pkg::ST_CHECK: begin
        cmd.start_div = !sts.skip;
      end
      ffr_pkg::ST_DIV: begin
        cmd.accept_div = sts.div_done && sts.div_exact;
      end
      ffr_pkg::ST_EMIT: begin
        cmd.load_out   = sts.out_free;
        cmd.next_stage = sts.out_free && !sts.last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
